@@ hdl/ctbd_pkg.sv @@
// Shared types and constants for the capacitive touch baseline detector.
package ctbd_pkg;

    localparam int SMP_W = 16;
    localparam int CH_W  = 2;
    localparam int DBC_W = 8;

    localparam logic [SMP_W-1:0] SENS_RST = 16'd100;
    localparam logic [SMP_W-1:0] TOL_RST  = 16'd50;
    localparam logic [DBC_W-1:0] DBC_RST  = 8'd3;

    localparam logic [1:0] CFG_SENSITIVITY    = 2'd0;
    localparam logic [1:0] CFG_WAVE_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_COUNT = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic             touch_event;
        logic [CH_W-1:0]  channel_out;
        logic             window_ready;
        logic [SMP_W-1:0] baseline_out;
    } t_out_req;

    typedef struct packed {
        logic             full;
        logic [SMP_W-1:0] lo;
        logic [SMP_W-1:0] hi;
        logic             dbnc_met;
    } t_win_stat;

endpackage

@@ hdl/ctbd_win_stats.sv @@
// Window statistics: fill check, min/max tree and below-threshold count.
module ctbd_win_stats
    import ctbd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic [WINDOW_DEPTH-1:0][SMP_W-1:0] i_win,
    input  logic [SMP_W-1:0]                   i_thr,
    input  logic [DBC_W-1:0]                   i_dbnc,
    output t_win_stat                          o_stat
);

    localparam int LVL   = $clog2(WINDOW_DEPTH);
    localparam int LEAVES = 1 << LVL;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W = (CNT_W > DBC_W) ? CNT_W : DBC_W;

    logic [SMP_W-1:0] lo_t [1:2*LEAVES-1];
    logic [SMP_W-1:0] hi_t [1:2*LEAVES-1];
    logic [CNT_W-1:0] cnt;
    logic             full;

    always_comb begin
        for (int k = 0; k < LEAVES; k++) begin
            if (k < WINDOW_DEPTH) begin
                lo_t[LEAVES+k] = i_win[k];
                hi_t[LEAVES+k] = i_win[k];
            end else begin
                lo_t[LEAVES+k] = i_win[0];
                hi_t[LEAVES+k] = i_win[0];
            end
        end
        for (int k = LEAVES - 1; k >= 1; k--) begin
            lo_t[k] = (lo_t[2*k] < lo_t[2*k+1]) ? lo_t[2*k] : lo_t[2*k+1];
            hi_t[k] = (hi_t[2*k] > hi_t[2*k+1]) ? hi_t[2*k] : hi_t[2*k+1];
        end
    end

    always_comb begin
        cnt  = '0;
        full = 1'b1;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            cnt = cnt + CNT_W'(i_win[i] < i_thr);
            if (i_win[i] == '0) begin
                full = 1'b0;
            end
        end
    end

    assign o_stat.full     = full;
    assign o_stat.lo       = lo_t[1];
    assign o_stat.hi       = hi_t[1];
    assign o_stat.dbnc_met = CMP_W'(cnt) > CMP_W'(i_dbnc);

endmodule

@@ hdl/cap_touch_baseline_detector.sv @@
// Top level of the capacitive touch baseline detector.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | request   | i_in_valid/o_in_ready  | i_in_req   (channel, sample)
//  out     | result    | o_out_valid/i_out_ready| o_out_req  (event, ch, rdy, base)
//  cfg     | write     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One request per cycle unless output stalls; input and result are registered.
// The input register feeds the window min/max tree and pad update in one pass;
// pad state and the result register load on the same edge.
// A stalled output holds the result and the input register keeps accepting
// as long as the result register drains.
// Synchronous active-low reset clears all windows, baselines, thresholds and flags.
module cap_touch_baseline_detector
    import ctbd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int NUM_PADS     = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [SMP_W-1:0] i_cfg_data
);

    localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    logic [WINDOW_DEPTH-1:0][SMP_W-1:0] r_win [NUM_PADS];
    logic [SMP_W-1:0]                   r_base [NUM_PADS];
    logic [SMP_W-1:0]                   r_thr [NUM_PADS];
    logic [NUM_PADS-1:0]                r_rep;

    logic [SMP_W-1:0] r_sens;
    logic [SMP_W-1:0] r_tol;
    logic [DBC_W-1:0] r_dbnc;

    logic     r_in_vld;
    t_in_req  r_in;
    logic     r_out_vld;
    t_out_req r_out;

    logic                               adv;
    logic                               pad_ok;
    logic [PAD_W-1:0]                   pad;
    logic [WINDOW_DEPTH-1:0][SMP_W-1:0] cur_win;
    logic [WINDOW_DEPTH-1:0][SMP_W-1:0] win_sh;
    logic [SMP_W-1:0]                   cur_base;
    logic [SMP_W-1:0]                   cur_thr;
    logic                               cur_rep;
    t_win_stat                          stat;
    logic [SMP_W:0]                     mid_sum;
    logic [SMP_W-1:0]                   mid;
    logic                               stable;
    logic                               take_base;
    logic                               fire;
    logic [SMP_W-1:0]                   new_thr;
    t_out_req                           n_out;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    assign pad_ok = 32'(r_in.channel) < NUM_PADS;
    assign pad    = PAD_W'(r_in.channel);

    always_comb begin
        if (pad_ok) begin
            cur_win  = r_win[pad];
            cur_base = r_base[pad];
            cur_thr  = r_thr[pad];
            cur_rep  = r_rep[pad];
        end else begin
            cur_win  = '0;
            cur_base = '0;
            cur_thr  = '0;
            cur_rep  = 1'b0;
        end
    end

    // newest sample enters slot zero
    assign win_sh = {cur_win[WINDOW_DEPTH-2:0], r_in.sample};

    ctbd_win_stats #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_stats (
        .i_win (win_sh),
        .i_thr (cur_thr),
        .i_dbnc(r_dbnc),
        .o_stat(stat)
    );

    assign mid_sum   = {1'b0, stat.hi} + {1'b0, stat.lo};
    assign mid       = mid_sum[SMP_W:1];
    assign stable    = (stat.hi - stat.lo) < r_tol;
    assign take_base = stat.full && stable && (mid > cur_thr);
    assign fire      = stat.full && !stable && !cur_rep && stat.dbnc_met;
    assign new_thr   = (mid > r_sens) ? (mid - r_sens) : '0;

    always_comb begin
        n_out.touch_event  = pad_ok && fire;
        n_out.channel_out  = r_in.channel;
        n_out.window_ready = pad_ok && stat.full;
        n_out.baseline_out = !pad_ok ? '0 : (take_base ? mid : cur_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RST;
            r_tol  <= TOL_RST;
            r_dbnc <= DBC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSITIVITY: begin
                    r_sens <= i_cfg_data;
                end
                CFG_WAVE_TOLERANCE: begin
                    r_tol <= i_cfg_data;
                end
                CFG_DEBOUNCE_COUNT: begin
                    r_dbnc <= i_cfg_data[DBC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PADS; p++) begin
                r_win[p]  <= '0;
                r_base[p] <= '0;
                r_thr[p]  <= '0;
            end
            r_rep <= '0;
        end else if (adv && pad_ok) begin
            r_win[pad] <= win_sh;
            if (take_base) begin
                r_base[pad] <= mid;
                r_thr[pad]  <= new_thr;
                r_rep[pad]  <= 1'b0;
            end else if (fire) begin
                r_rep[pad] <= 1'b1;
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the capacitive touch baseline detector: predicts each pad report.
module testbench;
    import ctbd_pkg::*;

    localparam int DEPTH = 8;
    localparam int PADS  = 4;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_req          i_in_req    = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_req         o_out_req;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_idx   = CFG_SENSITIVITY;
    logic [SMP_W-1:0] i_cfg_data  = '0;

    logic [SMP_W-1:0] win_q [PADS][DEPTH];
    logic [SMP_W-1:0] base_q [PADS];
    logic [SMP_W-1:0] thr_q [PADS];
    logic             reported_q [PADS];
    logic [SMP_W-1:0] sens_q = SENS_RST;
    logic [SMP_W-1:0] tol_q  = TOL_RST;
    logic [DBC_W-1:0] dbc_q  = DBC_RST;
    logic [SMP_W-1:0] pad_level [PADS];

    t_out_req reports_due [$];
    t_out_req want;
    int       mismatch_cnt = 0;
    int       snd_idle_pct = 0;
    int       rcv_idle_pct = 0;
    int       hold_left    = 0;

    cap_touch_baseline_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_req track_pad(input t_in_req rq);
        t_out_req         rsp;
        logic [SMP_W-1:0] lo;
        logic [SMP_W-1:0] hi;
        logic [SMP_W:0]   mid;
        logic             full;
        int               below;
        int               ch;
        int               i;
        rsp = '0;
        rsp.channel_out = rq.channel;
        ch = int'(rq.channel);
        if (ch >= PADS)
            return rsp;
        for (i = DEPTH - 1; i > 0; i--)
            win_q[ch][i] = win_q[ch][i-1];
        win_q[ch][0] = rq.sample;
        full = 1'b1;
        lo   = '1;
        hi   = '0;
        for (i = 0; i < DEPTH; i++) begin
            if (win_q[ch][i] == '0)
                full = 1'b0;
            if (win_q[ch][i] < lo)
                lo = win_q[ch][i];
            if (win_q[ch][i] > hi)
                hi = win_q[ch][i];
        end
        if (full) begin
            mid = ({1'b0, hi} + {1'b0, lo}) >> 1;
            if (hi - lo < tol_q) begin
                if (mid > {1'b0, thr_q[ch]}) begin
                    base_q[ch]     = mid[SMP_W-1:0];
                    thr_q[ch]      = (mid > {1'b0, sens_q}) ? mid[SMP_W-1:0] - sens_q : '0;
                    reported_q[ch] = 1'b0;
                end
            end else if (!reported_q[ch]) begin
                below = 0;
                for (i = 0; i < DEPTH; i++)
                    if (win_q[ch][i] < thr_q[ch])
                        below++;
                if (below > int'(dbc_q)) begin
                    reported_q[ch]  = 1'b1;
                    rsp.touch_event = 1'b1;
                end
            end
        end
        rsp.window_ready = full;
        rsp.baseline_out = base_q[ch];
        return rsp;
    endfunction

    function automatic void cmp_field(input string name, input logic [SMP_W-1:0] want_v,
                                      input logic [SMP_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (reports_due.size() == 0) begin
                $error("pad report with no measurement pending");
                mismatch_cnt++;
            end else begin
                want = reports_due.pop_front();
                cmp_field("touch_event", SMP_W'(want.touch_event),
                          SMP_W'(o_out_req.touch_event));
                cmp_field("channel_out", SMP_W'(want.channel_out),
                          SMP_W'(o_out_req.channel_out));
                cmp_field("window_ready", SMP_W'(want.window_ready),
                          SMP_W'(o_out_req.window_ready));
                cmp_field("baseline_out", want.baseline_out, o_out_req.baseline_out);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic offer_meas(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
        t_in_req rq;
        rq.channel = ch;
        rq.sample  = smp;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        reports_due.push_back(track_pad(rq));
        @(negedge i_clk);
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [SMP_W-1:0] sens, input logic [SMP_W-1:0] tol,
                               input logic [DBC_W-1:0] dbc);
        drain_reports();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SENSITIVITY;
        i_cfg_data <= sens;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WAVE_TOLERANCE;
        i_cfg_data <= tol;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DEBOUNCE_COUNT;
        i_cfg_data <= {{(SMP_W-DBC_W){1'b0}}, dbc};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sens_q = sens;
        tol_q  = tol;
        dbc_q  = dbc;
        @(negedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] near_level(input logic [SMP_W-1:0] lvl);
        int noise;
        int v;
        noise = (int'(tol_q) / 3 > 200) ? 200 : int'(tol_q) / 3;
        v = int'(lvl) + int'($urandom_range(2 * noise)) - noise;
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return v[SMP_W-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] press_level(input logic [SMP_W-1:0] lvl);
        int gap;
        if (int'(lvl) > int'(sens_q) + 2) begin
            gap = int'(lvl) - int'(sens_q) - 1;
            return SMP_W'(lvl - sens_q - $urandom_range(1, (gap > 2000) ? 2000 : gap));
        end
        return SMP_W'($urandom_range(1, 50));
    endfunction

    // mostly settle / press / release bursts, some raw noise and broken windows
    task automatic run_pad_traffic(input int n_items);
        int sent;
        int pick;
        int ch;
        int other;
        int k;
        int settle;
        int press;
        int rel;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            ch   = $urandom_range(PADS - 1);
            if (pick < 60) begin
                if ($urandom_range(3) == 0)
                    pad_level[ch] = SMP_W'($urandom_range(1, 400));
                else if ($urandom_range(1) == 0)
                    pad_level[ch] = SMP_W'($urandom_range(200, 65000));
                settle = 8 + $urandom_range(6);
                press  = 2 + $urandom_range(8);
                rel    = 4 + $urandom_range(6);
                for (k = 0; k < settle + press + rel; k++) begin
                    if ($urandom_range(99) < 15) begin
                        other = $urandom_range(PADS - 1);
                        offer_meas(CH_W'(other), near_level(pad_level[other]));
                        sent++;
                    end
                    if (k >= settle && k < settle + press)
                        offer_meas(CH_W'(ch), press_level(pad_level[ch]));
                    else
                        offer_meas(CH_W'(ch), near_level(pad_level[ch]));
                    sent++;
                end
            end else if (pick < 85) begin
                if ($urandom_range(7) == 0)
                    offer_meas(CH_W'(ch), '0);
                else if ($urandom_range(7) == 0)
                    offer_meas(CH_W'(ch), '1);
                else
                    offer_meas(CH_W'(ch), SMP_W'($urandom_range(16'hFFFF)));
                sent++;
            end else begin
                settle = 2 + $urandom_range(4);
                for (k = 0; k < settle; k++)
                    offer_meas(CH_W'(ch), near_level(pad_level[ch]));
                offer_meas(CH_W'(ch), '0);
                sent += settle + 1;
            end
        end
    endtask

    task automatic test_directed();
        int k;
        // threshold underflow and midpoint rounding
        for (k = 0; k < 8; k++)
            offer_meas(2'd2, (k < 4) ? 16'd59 : 16'd60);
        // top of range baseline
        for (k = 0; k < 8; k++)
            offer_meas(2'd0, 16'hFFFF);
        offer_meas(2'd1, 16'd0);
        // press: one event, then no repeat while reported
        for (k = 0; k < 5; k++)
            offer_meas(2'd0, 16'd1);
        offer_meas(2'd3, 16'd1);
        // zero sensitivity: second stable window sits at the threshold
        load_config(16'd0, TOL_RST, DBC_RST);
        offer_meas(2'd2, 16'd59);
        offer_meas(2'd2, 16'd59);
    endtask

    task automatic test_register_extremes();
        load_config(16'd0, 16'hFFFF, 8'd0);
        run_pad_traffic(60);
        load_config(16'hFFFF, 16'd0, 8'hFF);
        run_pad_traffic(60);
    endtask

    task automatic test_idle_mix(input int n_items);
        int k;
        for (k = 0; k < 5; k++) begin
            load_config(SMP_W'($urandom_range(20, 3000)), SMP_W'($urandom_range(10, 400)),
                        DBC_W'($urandom_range(7)));
            run_pad_traffic(n_items / 5);
        end
    endtask

    task automatic test_input_stall();
        load_config(SENS_RST, TOL_RST, DBC_RST);
        hold_left = 250;
        run_pad_traffic(40);
    endtask

    initial begin
        int p;
        int k;
        for (p = 0; p < PADS; p++) begin
            for (k = 0; k < DEPTH; k++)
                win_q[p][k] = '0;
            base_q[p]     = '0;
            thr_q[p]      = '0;
            reported_q[p] = 1'b0;
            pad_level[p]  = SMP_W'($urandom_range(200, 65000));
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 26;
        rcv_idle_pct = 70;
        test_directed();
        test_register_extremes();
        test_idle_mix(250);

        snd_idle_pct = 70;
        rcv_idle_pct = 26;
        test_idle_mix(300);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_idle_mix(300);
        test_input_stall();

        drain_reports();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
